// ----- src/uvg_pkg.sv -----
// uvg_pkg: types and constants shared by the uuid version 7 generator
// no dependencies
`default_nettype none

package uvg_pkg;

    localparam int unsigned TS_W   = 48;
    localparam int unsigned CNT_W  = 12;
    localparam int unsigned HALF_W = 64;
    localparam int unsigned RND_KEEP_W = 62;

    localparam logic [TS_W-1:0]  TS_MAX      = {TS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [3:0]       VERSION_NIB = 4'h7;
    localparam logic [1:0]       VARIANT     = 2'b10;

    // one result of the generator
    typedef struct packed {
        logic [HALF_W-1:0] uuid_high;
        logic [HALF_W-1:0] uuid_low;
        logic              exhausted;
    } t_result;

endpackage

`default_nettype wire

// ----- src/uuid_v7_monotonic_generator.sv -----
// uuid_v7_monotonic_generator: top level with input and result registers
// depends on uvg_pkg and uvg_core
//
// Issues one 128-bit uuid version 7 per request: 48-bit millisecond
// timestamp, version nibble 7, 12-bit monotonic counter, then 62 random
// bits under the variant bits 10. Readings above 2^48-1 are clamped. A
// reading not newer than the held timestamp bumps the counter; a full
// counter advances the timestamp by one. With timestamp and counter both
// at maximum the result is all zeros with o_exhausted set, state unchanged.
// Throughput is one request per cycle while i_out_ready does not stall the
// result register. An accepted request is held in the input register, then
// moves into the result register, raising o_out_valid, once that register
// is free or draining; the counter state updates at that same edge.
`default_nettype none

module uuid_v7_monotonic_generator
    import uvg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [HALF_W-1:0] i_observed_ms,
    input  wire logic [HALF_W-1:0] i_random_bits,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [HALF_W-1:0]      o_uuid_high,
    output logic [HALF_W-1:0]      o_uuid_low,
    output logic                   o_exhausted
);

    logic              r_in_valid;
    logic [HALF_W-1:0] r_obs;
    logic [HALF_W-1:0] r_rnd;
    logic              r_out_valid;
    t_result           r_res;
    t_result           core_res;
    logic              advance;

    // move a request into the result register when it is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_obs <= i_observed_ms;
            r_rnd <= i_random_bits;
        end
    end

    uvg_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_observed_ms (r_obs),
        .i_random_bits (r_rnd),
        .o_result      (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_uuid_high = r_res.uuid_high;
    assign o_uuid_low  = r_res.uuid_low;
    assign o_exhausted = r_res.exhausted;

endmodule

`default_nettype wire

// ----- src/uvg_core.sv -----
// uvg_core: held timestamp, sequence counter and uuid packing
// depends on uvg_pkg
`default_nettype none

module uvg_core
    import uvg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [HALF_W-1:0] i_observed_ms,
    input  wire logic [HALF_W-1:0] i_random_bits,
    output t_result                o_result
);

    logic [TS_W-1:0]  r_ts, n_ts;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_tv, n_tv;
    logic [TS_W-1:0]  reading;
    logic             newer;
    logic             exhausted;

    // clamp the reading to 48 bits
    assign reading = (i_observed_ms[HALF_W-1:TS_W] != '0) ? TS_MAX : i_observed_ms[TS_W-1:0];
    assign newer   = !r_tv || (reading > r_ts);

    // next timestamp and counter
    always_comb begin
        n_ts      = r_ts;
        n_cnt     = r_cnt;
        n_tv      = r_tv;
        exhausted = 1'b0;
        if (newer) begin
            n_ts  = reading;
            n_cnt = '0;
            n_tv  = 1'b1;
        end else if (r_cnt != CNT_MAX) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (r_ts == TS_MAX) begin
            exhausted = 1'b1;
        end else begin
            n_ts  = r_ts + TS_W'(1);
            n_cnt = '0;
        end
    end

    // pack the identifier, zero when exhausted
    always_comb begin
        o_result.exhausted = exhausted;
        if (exhausted) begin
            o_result.uuid_high = '0;
            o_result.uuid_low  = '0;
        end else begin
            o_result.uuid_high = {n_ts, VERSION_NIB, n_cnt};
            o_result.uuid_low  = {VARIANT, i_random_bits[RND_KEEP_W-1:0]};
        end
    end

    // state update once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= '0;
            r_cnt <= '0;
            r_tv  <= 1'b0;
        end else if (i_fire) begin
            r_ts  <= n_ts;
            r_cnt <= n_cnt;
            r_tv  <= n_tv;
        end
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for uuid_v7_monotonic_generator
// depends on uvg_pkg and the generator rtl; predicts each uuid and checks results in order

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import uvg_pkg::*;

    // one request as presented to the generator
    typedef struct packed {
        logic [HALF_W-1:0] observed_ms;
        logic [HALF_W-1:0] random_bits;
    } t_request;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              i_out_ready   = 1'b0;
    logic [HALF_W-1:0] i_observed_ms = '0;
    logic [HALF_W-1:0] i_random_bits = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [HALF_W-1:0] o_uuid_high;
    logic [HALF_W-1:0] o_uuid_low;
    logic              o_exhausted;

    t_request    request_queue[$];
    t_result     uuid_expected[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    logic        req_taken      = 1'b0;

    // predictor copy of the generator state
    logic [TS_W-1:0]  held_ms   = '0;
    logic [CNT_W-1:0] seq_count = '0;
    logic             ms_valid  = 1'b0;

    uuid_v7_monotonic_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_observed_ms (i_observed_ms),
        .i_random_bits (i_random_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_uuid_high   (o_uuid_high),
        .o_uuid_low    (o_uuid_low),
        .o_exhausted   (o_exhausted)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // next uuid for one accepted request, advancing the predictor state
    function automatic t_result issue_uuid(input logic [HALF_W-1:0] obs,
                                           input logic [HALF_W-1:0] rnd);
        logic [TS_W-1:0] reading;
        t_result         res;
        reading = (|obs[HALF_W-1:TS_W]) ? TS_MAX : obs[TS_W-1:0];
        res     = '0;
        if (!ms_valid || reading > held_ms) begin
            held_ms   = reading;
            seq_count = '0;
            ms_valid  = 1'b1;
        end else if (seq_count != CNT_MAX) begin
            seq_count = seq_count + 1'b1;
        end else if (held_ms == TS_MAX) begin
            // timestamp and counter spent: zero uuid, state kept
            res.exhausted = 1'b1;
            return res;
        end else begin
            held_ms   = held_ms + 1'b1;
            seq_count = '0;
        end
        res.uuid_high = {held_ms, VERSION_NIB, seq_count};
        res.uuid_low  = {VARIANT, rnd[RND_KEEP_W-1:0]};
        return res;
    endfunction

    // idle length: mostly short, a few long, none in quiet stretches
    function automatic int unsigned draw_gap();
        int unsigned r;
        if ((cycle_count / 1500) % 4 == 3)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [HALF_W-1:0] rand48();
        return rand64() & {16'h0, TS_MAX};
    endfunction

    task automatic report_mismatch(input string what, input logic [HALF_W-1:0] got,
                                   input logic [HALF_W-1:0] want);
        mismatch_count++;
        $display("mismatch on %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic push_request(input logic [HALF_W-1:0] obs, input logic [HALF_W-1:0] rnd);
        t_request req;
        req.observed_ms = obs;
        req.random_bits = rnd;
        request_queue.push_back(req);
    endtask

    // hold the sender until every request has been answered
    task automatic wait_idle();
        while (request_queue.size() != 0 || i_in_valid || uuid_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // monitor: check results, predict accepted requests
    always @(posedge i_clk) begin
        t_result want;
        cycle_count <= cycle_count + 1;
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (uuid_expected.size() == 0) begin
                report_mismatch("unexpected result", o_uuid_high, '0);
            end else begin
                want = uuid_expected.pop_front();
                if (o_uuid_high !== want.uuid_high)
                    report_mismatch("uuid_high", o_uuid_high, want.uuid_high);
                if (o_uuid_low !== want.uuid_low)
                    report_mismatch("uuid_low", o_uuid_low, want.uuid_low);
                if (o_exhausted !== want.exhausted)
                    report_mismatch("exhausted", {63'h0, o_exhausted}, {63'h0, want.exhausted});
            end
        end
        if (req_taken)
            uuid_expected.push_back(issue_uuid(i_observed_ms, i_random_bits));
    end

    // driver: requests from the queue with random gaps, random result stalls
    always @(negedge i_clk) begin
        logic     next_valid;
        t_request req;
        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (req_taken)
                next_valid = 1'b0;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_queue.size() > 0) begin
                    req = request_queue.pop_front();
                    i_observed_ms <= req.observed_ms;
                    i_random_bits <= req.random_bits;
                    next_valid = 1'b1;
                    send_gap   = draw_gap();
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
        i_in_valid <= next_valid;
    end

    // stimulus and end of run
    initial begin
        logic [HALF_W-1:0] cur_ms;
        logic [HALF_W-1:0] reading;
        int unsigned       r;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first request at zero, equal, older, newer, variant edges
        push_request(64'd0, 64'h0);
        push_request(64'd0, '1);
        push_request(64'd0, 64'h4000_0000_0000_0000);
        push_request(64'd7, 64'h8000_0000_0000_0000);
        push_request(64'd3, 64'hC000_0000_0000_0000);
        push_request(64'd7, 64'h3FFF_FFFF_FFFF_FFFF);
        push_request(64'd8, rand64());
        push_request(64'd1, rand64());
        push_request(64'h0000_0000_FFFF_FFFF, rand64());
        push_request(64'h0000_0000_FFFF_FFFF, rand64());
        push_request(64'h0000_0000_AAAA_5555, rand64());
        push_request(64'h0000_0000_5555_AAAA, rand64());

        // random: a slowly moving clock with repeats, stale and jumping readings
        cur_ms = {18'h0, 14'($urandom_range(1, 16383)), $urandom};
        repeat (820) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                reading = cur_ms;
            end else if (r < 70) begin
                cur_ms  = cur_ms + $urandom_range(1, 3);
                reading = cur_ms;
            end else if (r < 85) begin
                reading = cur_ms - $urandom_range(1, 1000);
            end else if (r < 95) begin
                reading = rand48() % (cur_ms + 1);
            end else begin
                cur_ms  = cur_ms + {24'h0, 8'($urandom_range(0, 255)), $urandom};
                reading = cur_ms;
            end
            push_request(reading, rand64());
        end

        wait_idle();

        // clamped readings at the top timestamp, then stale ones
        push_request('1, rand64());
        push_request(64'h0001_0000_0000_0000, rand64());
        push_request({16'h0, TS_MAX}, rand64());
        push_request({16'h0, TS_MAX - 1'b1}, rand64());
        repeat (6)
            push_request(rand64(), rand64());

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // timeout
    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
src/uvg_pkg.sv
src/uvg_core.sv
src/uuid_v7_monotonic_generator.sv
test/testbench.sv
